/* rtl/lfb_pkg.sv */
// Shared types and constants for the LED matrix chain frame builder.
package lfb_pkg;

	localparam int CHAIN_MAX_DEF = 8;
	localparam int ROWS          = 8;

	localparam int CMD_W   = 3;
	localparam int DEV_W   = 3;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 3;
	localparam int VAL_W   = 8;
	localparam int OPC_W   = 4;
	localparam int CNT_W   = 4;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	localparam logic [OPC_W-1:0]  OP_NOP       = 4'd0;
	localparam logic [OPC_W-1:0]  OP_BRIGHT    = 4'd10;
	localparam logic [OPC_W-1:0]  OP_SCAN_LIM  = 4'd11;
	localparam logic [OPC_W-1:0]  OP_POWER     = 4'd12;
	localparam logic [VAL_W-1:0]  INTENSITY_LEVELS = 8'd16;
	localparam logic [VAL_W-1:0]  SCAN_LIMITS      = 8'd8;
	localparam logic [BYTE_W-1:0] LED_TOP_BIT      = 8'h80;
	localparam logic [ROW_W-1:0]  LAST_FRAME       = 3'd7;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET_LED   = 3'd0,
		CMD_CLEAR     = 3'd1,
		CMD_INTENSITY = 3'd2,
		CMD_SCANLIMIT = 3'd3,
		CMD_SHUTDOWN  = 3'd4,
		CMD_RAW       = 3'd5
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic step;
	} dp_ctl_t;

	typedef struct packed {
		logic ok;
		logic set_led;
		logic last_word;
		logic out_free;
	} dp_sts_t;

endpackage

/* rtl/lfb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/lfb_ctrl.sv */
// Command sequencer for the frame builder.
module lfb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lfb_pkg::dp_sts_t  sts,
	output lfb_pkg::dp_ctl_t  ctl
);

	lfb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lfb_pkg::ST_IDLE: begin
				if (in_valid && sts.ok) begin
					state_d = sts.set_led ? lfb_pkg::ST_READ : lfb_pkg::ST_EMIT;
				end
			end
			lfb_pkg::ST_READ: begin
				state_d = lfb_pkg::ST_EMIT;
			end
			lfb_pkg::ST_EMIT: begin
				if (sts.out_free && sts.last_word) begin
					state_d = lfb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		ctl.load   = 1'b0;
		ctl.update = 1'b0;
		ctl.step   = 1'b0;
		case (state_q)
			lfb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid && sts.ok;
			end
			lfb_pkg::ST_READ: begin
				ctl.update = 1'b1;
			end
			lfb_pkg::ST_EMIT: begin
				ctl.step = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/lfb_dp.sv */
// Datapath: chain length, shadow bitmap, frame counters and output register.
module lfb_dp #(
	parameter int CHAIN_MAX = lfb_pkg::CHAIN_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lfb_pkg::CNT_W-1:0]   cfg_data,
	input  logic [lfb_pkg::CMD_W-1:0]   command,
	input  logic [lfb_pkg::DEV_W-1:0]   device,
	input  logic [lfb_pkg::ROW_W-1:0]   row,
	input  logic [lfb_pkg::COL_W-1:0]   col,
	input  logic                        flag,
	input  logic [lfb_pkg::VAL_W-1:0]   value,
	input  logic [lfb_pkg::OPC_W-1:0]   opcode,
	input  lfb_pkg::dp_ctl_t            ctl,
	output lfb_pkg::dp_sts_t            sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lfb_pkg::WORD_W-1:0]  word,
	output logic                        frame_end,
	output logic                        last
);

	localparam int DEPTH  = CHAIN_MAX * lfb_pkg::ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [lfb_pkg::CNT_W-1:0] MAX_CNT = lfb_pkg::CNT_W'(CHAIN_MAX);

	logic [lfb_pkg::CNT_W-1:0]  dev_count_q;
	lfb_pkg::command_t          cmd_in, cmd_q;
	logic [lfb_pkg::DEV_W-1:0]  dev_q;
	logic [lfb_pkg::COL_W-1:0]  col_q;
	logic                       flag_q;
	logic [lfb_pkg::OPC_W-1:0]  op_q, op_ld, op_cur;
	logic [lfb_pkg::BYTE_W-1:0] data_q, data_ld, data_cur;
	logic [ADDR_W-1:0]          addr_in, addr_q;
	logic [DEPTH-1:0]           vld_q, vld_d;
	logic [lfb_pkg::DEV_W-1:0]  pos_q, pos_first;
	logic [lfb_pkg::ROW_W-1:0]  frame_q;
	logic [lfb_pkg::BYTE_W-1:0] ram_rdata, shadow_old, shadow_new, led_mask;
	logic                       dev_ok, cmd_ok;
	logic                       out_valid_q, frame_end_q, last_q;
	logic [lfb_pkg::WORD_W-1:0] word_q, word_nxt;

	assign cmd_in    = lfb_pkg::command_t'(command);
	assign addr_in   = ADDR_W'({device, row});
	assign pos_first = lfb_pkg::DEV_W'(dev_count_q - 4'd1);

	// chain length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q <= MAX_CNT;
		end else if (cfg_we) begin
			if (cfg_data == '0 || cfg_data > MAX_CNT) begin
				dev_count_q <= MAX_CNT;
			end else begin
				dev_count_q <= cfg_data;
			end
		end
	end

	// command check and per-command word contents
	always_comb begin
		dev_ok  = {1'b0, device} < dev_count_q;
		cmd_ok  = 1'b0;
		op_ld   = lfb_pkg::OP_NOP;
		data_ld = '0;
		case (cmd_in)
			lfb_pkg::CMD_SET_LED: begin
				cmd_ok = 1'b1;
				op_ld  = {1'b0, row} + 4'd1;
			end
			lfb_pkg::CMD_CLEAR: begin
				cmd_ok = 1'b1;
			end
			lfb_pkg::CMD_INTENSITY: begin
				cmd_ok  = value < lfb_pkg::INTENSITY_LEVELS;
				op_ld   = lfb_pkg::OP_BRIGHT;
				data_ld = value;
			end
			lfb_pkg::CMD_SCANLIMIT: begin
				cmd_ok  = value < lfb_pkg::SCAN_LIMITS;
				op_ld   = lfb_pkg::OP_SCAN_LIM;
				data_ld = value;
			end
			lfb_pkg::CMD_SHUTDOWN: begin
				cmd_ok  = 1'b1;
				op_ld   = lfb_pkg::OP_POWER;
				data_ld = flag ? 8'd0 : 8'd1;
			end
			lfb_pkg::CMD_RAW: begin
				cmd_ok  = 1'b1;
				op_ld   = opcode;
				data_ld = value;
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	assign sts.ok        = dev_ok && cmd_ok;
	assign sts.set_led   = (cmd_in == lfb_pkg::CMD_SET_LED);
	assign sts.last_word = (pos_q == '0)
		&& (cmd_q != lfb_pkg::CMD_CLEAR || frame_q == lfb_pkg::LAST_FRAME);
	assign sts.out_free  = !out_valid_q || out_ready;

	// shadow read-modify-write; entries without a valid bit read as zero
	assign led_mask   = lfb_pkg::LED_TOP_BIT >> col_q;
	assign shadow_old = vld_q[addr_q] ? ram_rdata : '0;
	assign shadow_new = flag_q ? (shadow_old | led_mask) : (shadow_old & ~led_mask);

	lfb_ram #(
		.WIDTH(lfb_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_shadow (
		.clk  (clk),
		.we   (ctl.update),
		.waddr(addr_q),
		.wdata(shadow_new),
		.re   (ctl.load),
		.raddr(addr_in),
		.rdata(ram_rdata)
	);

	always_comb begin
		vld_d = vld_q;
		if (ctl.load && cmd_in == lfb_pkg::CMD_CLEAR) begin
			for (int i = 0; i < lfb_pkg::ROWS; i++) begin
				vld_d[ADDR_W'({device, 3'(i)})] = 1'b0;
			end
		end
		if (ctl.update) begin
			vld_d[addr_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_d;
		end
	end

	// command registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd_in;
			dev_q  <= device;
			col_q  <= col;
			flag_q <= flag;
			op_q   <= op_ld;
			addr_q <= addr_in;
		end
		if (ctl.load) begin
			data_q <= data_ld;
		end else if (ctl.update) begin
			data_q <= shadow_new;
		end
	end

	// position in frame and frame number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			frame_q <= '0;
		end else if (ctl.load) begin
			pos_q   <= pos_first;
			frame_q <= '0;
		end else if (ctl.step) begin
			if (pos_q == '0) begin
				pos_q   <= pos_first;
				frame_q <= frame_q + 3'd1;
			end else begin
				pos_q <= pos_q - 3'd1;
			end
		end
	end

	assign op_cur   = (cmd_q == lfb_pkg::CMD_CLEAR) ? ({1'b0, frame_q} + 4'd1) : op_q;
	assign data_cur = (cmd_q == lfb_pkg::CMD_CLEAR) ? '0 : data_q;
	assign word_nxt = (pos_q == dev_q) ? {4'b0000, op_cur, data_cur} : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			word_q      <= word_nxt;
			frame_end_q <= (pos_q == '0);
			last_q      <= sts.last_word;
		end
	end

	assign out_valid = out_valid_q;
	assign word      = word_q;
	assign frame_end = frame_end_q;
	assign last      = last_q;

endmodule

/* rtl/led_matrix_chain_frame_builder.sv */
// Top level of the LED matrix chain frame builder.
//
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+------------------------------
//  s_axis   | tvalid tready tdata[23:0] tuser[2:0]      | one command
//  m_axis   | tvalid tready tdata[15:0] tuser[0] tlast  | one chain word
//  cfg      | cfg_we cfg_data[3:0]                      | chain length write
//
// A command is accepted in the idle state, then its words go out in order: device_count
// words per frame, eight frames for clear device, one frame for the others. Set LED first
// passes a read state for the shadow RAM read. A rejected command is taken and sends no words.
// Reset clears the shadow bitmap at once through per-entry valid bits.
// Output stalls hold the word sequencer; the next command is taken while
// the last word of the previous one still waits in the output register.
module led_matrix_chain_frame_builder #(
	parameter int CHAIN_MAX = lfb_pkg::CHAIN_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lfb_pkg::CNT_W-1:0]          cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// device[2:0] row[5:3] col[8:6] flag[9] value[17:10] opcode[21:18], zero pad
	input  logic [lfb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// command[2:0]
	input  logic [lfb_pkg::CMD_W-1:0]          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// word[15:0]
	output logic [lfb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// frame_end[0]
	output logic [0:0]                         m_axis_tuser,
	output logic                               m_axis_tlast
);

	lfb_pkg::dp_ctl_t ctl;
	lfb_pkg::dp_sts_t sts;
	logic             frame_end;

	lfb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.ctl     (ctl)
	);

	lfb_dp #(
		.CHAIN_MAX(CHAIN_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.command  (s_axis_tuser),
		.device   (s_axis_tdata[2:0]),
		.row      (s_axis_tdata[5:3]),
		.col      (s_axis_tdata[8:6]),
		.flag     (s_axis_tdata[9]),
		.value    (s_axis_tdata[17:10]),
		.opcode   (s_axis_tdata[21:18]),
		.ctl      (ctl),
		.sts      (sts),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.word     (m_axis_tdata),
		.frame_end(frame_end),
		.last     (m_axis_tlast)
	);

	assign m_axis_tuser = frame_end;

endmodule
